[hw/rtl/smsd_pkg.sv]
// ----------------------------------------------------------------------------
// smsd_pkg
// Shared constants, types and the ramp ROM of the microstep sine drive.
// ----------------------------------------------------------------------------
`default_nettype none

package smsd_pkg;

  parameter int unsigned Microsteps = 18;
  parameter int unsigned RomLast    = 18;
  parameter int unsigned RomIdxW    = $clog2(RomLast + 1);
  parameter int unsigned PosW       = $clog2(4 * Microsteps + 1);
  parameter int unsigned PosOutW    = 7;
  parameter int unsigned DutyW      = 9;
  parameter int unsigned SpeedW     = 16;
  parameter int unsigned CountW     = 32;

  parameter logic [CountW-1:0] TargetReset = 32'hFFFF_FFFF;

  parameter logic [DutyW-1:0] RampRom [RomLast+1] = '{
    9'd292, 9'd308, 9'd324, 9'd339, 9'd345, 9'd353, 9'd367, 9'd375, 9'd380, 9'd393,
    9'd415, 9'd420, 9'd425, 9'd430, 9'd435, 9'd439, 9'd443, 9'd447, 9'd451
  };

  // one input request
  typedef struct packed {
    logic              restart;
    logic [SpeedW-1:0] speed_time;
  } item_t;

  // one result
  typedef struct packed {
    logic [DutyW-1:0]   duty_a1;
    logic [DutyW-1:0]   duty_b1;
    logic [DutyW-1:0]   duty_a2;
    logic [DutyW-1:0]   duty_b2;
    logic               stopped;
    logic               speed_load;
    logic [SpeedW-1:0]  speed_value;
    logic [PosOutW-1:0] micro_position;
  } result_t;

  // indexes past the end of the table saturate to the last entry
  function automatic logic [DutyW-1:0] rom_read(input logic [PosW:0] idx);
    logic [RomIdxW-1:0] sat;
    sat = (idx > (PosW+1)'(RomLast)) ? RomIdxW'(RomLast) : RomIdxW'(idx);
    return RampRom[sat];
  endfunction

endpackage

`default_nettype wire

[hw/rtl/smsd_in_stage.sv]
// ----------------------------------------------------------------------------
// smsd_in_stage
// Input register: holds one request until the step logic takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module smsd_in_stage (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire smsd_pkg::item_t item_i,
  input  wire logic          take_i,
  output logic               valid_o,
  output smsd_pkg::item_t    item_o
);

  logic            valid_q, valid_d;
  smsd_pkg::item_t item_q;

  assign in_ready_o = !valid_q || take_i;
  assign valid_d    = in_valid_i ? 1'b1 : (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

[hw/rtl/smsd_step.sv]
// ----------------------------------------------------------------------------
// smsd_step
// Drive state, step target register and the per-tick duty computation.
// ----------------------------------------------------------------------------
`default_nettype none

module smsd_step (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [smsd_pkg::CountW-1:0] cfg_data_i,
  input  wire logic            advance_i,
  input  wire smsd_pkg::item_t item_i,
  output smsd_pkg::result_t    result_o
);

  localparam int unsigned PosW = smsd_pkg::PosW;
  localparam logic [PosW:0] M1 = (PosW+1)'(smsd_pkg::Microsteps);
  localparam logic [PosW:0] M2 = (PosW+1)'(2 * smsd_pkg::Microsteps);
  localparam logic [PosW:0] M3 = (PosW+1)'(3 * smsd_pkg::Microsteps);
  localparam logic [PosW:0] M4 = (PosW+1)'(4 * smsd_pkg::Microsteps);

  logic [smsd_pkg::CountW-1:0] target_q;
  logic [smsd_pkg::CountW-1:0] steps_q, steps_d, steps_cur;
  logic [PosW-1:0]             position_q, position_d, position_cur;
  logic [smsd_pkg::SpeedW-1:0] last_speed_q, last_speed_d, last_speed_cur;

  logic                   at_target;
  logic                   speed_change;
  logic [PosW:0]          pos_wrap, step;
  logic [PosW:0]          idx_x, idx_y;
  logic [smsd_pkg::DutyW-1:0] duty_x, duty_y;
  smsd_pkg::result_t      res;

  // restart clears the state ahead of this tick
  assign steps_cur      = item_i.restart ? '0 : steps_q;
  assign position_cur   = item_i.restart ? '0 : position_q;
  assign last_speed_cur = item_i.restart ? '0 : last_speed_q;

  assign at_target    = steps_cur >= target_q;
  assign speed_change = last_speed_cur != item_i.speed_time;

  assign pos_wrap = ({1'b0, position_cur} >= M4) ? '0 : {1'b0, position_cur};
  assign step     = pos_wrap + (PosW+1)'(1);

  // quadrant select: x feeds the falling coil end, y the rising one
  always_comb begin
    res = '0;
    if (step <= M1) begin
      idx_x = M1 - step + (PosW+1)'(1);
      idx_y = step;
    end else if (step <= M2) begin
      idx_x = M2 - step;
      idx_y = step - M1 - (PosW+1)'(1);
    end else if (step <= M3) begin
      idx_x = M3 - step + (PosW+1)'(1);
      idx_y = step - M2;
    end else begin
      idx_x = M4 - step;
      idx_y = step - M3 - (PosW+1)'(1);
    end
    duty_x = smsd_pkg::rom_read(idx_x);
    duty_y = smsd_pkg::rom_read(idx_y);

    if (at_target) begin
      res.stopped        = 1'b1;
      res.micro_position = smsd_pkg::PosOutW'(position_cur);
    end else begin
      if (step <= M1) begin
        res.duty_a1 = duty_x;
        res.duty_b1 = duty_y;
      end else if (step <= M2) begin
        res.duty_b1 = duty_x;
        res.duty_a2 = duty_y;
      end else if (step <= M3) begin
        res.duty_a2 = duty_x;
        res.duty_b2 = duty_y;
      end else begin
        res.duty_b2 = duty_x;
        res.duty_a1 = duty_y;
      end
      res.speed_load     = speed_change;
      res.speed_value    = speed_change ? item_i.speed_time : '0;
      res.micro_position = smsd_pkg::PosOutW'(step);
    end
  end

  always_comb begin
    steps_d      = steps_cur;
    position_d   = position_cur;
    last_speed_d = last_speed_cur;
    if (!at_target) begin
      steps_d      = steps_cur + smsd_pkg::CountW'(1);
      position_d   = PosW'(step);
      last_speed_d = item_i.speed_time;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q     <= smsd_pkg::TargetReset;
      steps_q      <= '0;
      position_q   <= '0;
      last_speed_q <= '0;
    end else begin
      if (cfg_we_i) begin
        target_q <= cfg_data_i;
      end
      if (advance_i) begin
        steps_q      <= steps_d;
        position_q   <= position_d;
        last_speed_q <= last_speed_d;
      end
    end
  end

  assign result_o = res;

  position_range_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, position_q} <= M4)
    else $error("position beyond four phases");

endmodule

`default_nettype wire

[hw/rtl/smsd_out_stage.sv]
// ----------------------------------------------------------------------------
// smsd_out_stage
// Result register: holds one result until the consumer takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module smsd_out_stage (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  output logic                   ready_o,
  input  wire smsd_pkg::result_t result_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output smsd_pkg::result_t      result_o
);

  logic              valid_q, valid_d;
  smsd_pkg::result_t result_q;

  assign ready_o = !valid_q || out_ready_i;
  assign valid_d = valid_i ? 1'b1 : (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

`default_nettype wire

[hw/rtl/stepper_microstep_sine_drive_unit.sv]
// ----------------------------------------------------------------------------
// stepper_microstep_sine_drive_unit
// Bipolar stepper microstep drive: one set of coil duties per timer tick.
// ----------------------------------------------------------------------------
// Takes one tick request per clock while the consumer takes results, and
// returns one result per request. Each request passes through the input
// register, then the result register, before its result is presented. The
// position, step total and last period are updated as a request moves from
// the input register to the result register, so consecutive ticks see each
// other's state. Duties come from a 19-entry ramp table; once the step total
// reaches step_target the block reports stopped with zero duties until a
// restart request or a larger step target. The step target can be rewritten
// at any time through the cfg channel, which is always ready; it should only
// change while no requests are in flight.
`default_nettype none

module stepper_microstep_sine_drive_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,

  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [smsd_pkg::CountW-1:0]   cfg_data_i,

  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          restart_i,
  input  wire logic [smsd_pkg::SpeedW-1:0]   speed_time_i,

  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [smsd_pkg::DutyW-1:0]         duty_a1_o,
  output logic [smsd_pkg::DutyW-1:0]         duty_b1_o,
  output logic [smsd_pkg::DutyW-1:0]         duty_a2_o,
  output logic [smsd_pkg::DutyW-1:0]         duty_b2_o,
  output logic                               stopped_o,
  output logic                               speed_load_o,
  output logic [smsd_pkg::SpeedW-1:0]        speed_value_o,
  output logic [smsd_pkg::PosOutW-1:0]       micro_position_o
);

  smsd_pkg::item_t   item_in, item_q;
  smsd_pkg::result_t res_step, res_out;
  logic              item_valid, out_take, advance;

  assign cfg_ready_o = 1'b1;

  assign item_in.restart    = restart_i;
  assign item_in.speed_time = speed_time_i;

  assign advance = item_valid && out_take;

  smsd_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .item_i     (item_in),
    .take_i     (out_take),
    .valid_o    (item_valid),
    .item_o     (item_q)
  );

  smsd_step u_step (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .advance_i  (advance),
    .item_i     (item_q),
    .result_o   (res_step)
  );

  smsd_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (item_valid),
    .ready_o     (out_take),
    .result_i    (res_step),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (res_out)
  );

  assign duty_a1_o        = res_out.duty_a1;
  assign duty_b1_o        = res_out.duty_b1;
  assign duty_a2_o        = res_out.duty_a2;
  assign duty_b2_o        = res_out.duty_b2;
  assign stopped_o        = res_out.stopped;
  assign speed_load_o     = res_out.speed_load;
  assign speed_value_o    = res_out.speed_value;
  assign micro_position_o = res_out.micro_position;

  stopped_quiet_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && stopped_o) |->
      (duty_a1_o == '0 && duty_b1_o == '0 && duty_a2_o == '0 && duty_b2_o == '0 &&
       !speed_load_o))
    else $error("stopped result drives the coils");

  no_load_zero_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !speed_load_o) |-> speed_value_o == '0)
    else $error("period value without reload");

  two_coils_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $countones({duty_a1_o != '0, duty_b1_o != '0,
                                duty_a2_o != '0, duty_b2_o != '0}) <= 2)
    else $error("more than two coil ends driven");

  result_after_request_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(item_valid))
    else $error("result without a request");

endmodule

`default_nettype wire
